### rtl/core/qtsc_pkg.sv
// Package for the tensor storage checker: status codes, type classes, the
// per-type geometry table and the pipeline control and stage payload types.
// No dependencies.
package qtsc_pkg;

  localparam int unsigned MAX_DIMS   = 4;
  localparam int unsigned TYPE_COUNT = 43;
  localparam int unsigned TABLE_ROWS = 43;
  localparam int unsigned MAX_RANK   = (MAX_DIMS < 4) ? MAX_DIMS : 4;
  localparam int unsigned TBL_IW     = $clog2(TABLE_ROWS);
  localparam int unsigned NSTAGE     = 8;

  typedef enum logic [3:0] {
    ST_OK = 4'd0,
    ST_UNKNOWN,
    ST_REMOVED,
    ST_RESERVED,
    ST_NEWER,
    ST_NOGEOM,
    ST_RANK,
    ST_ZERODIM,
    ST_BLOCK,
    ST_OVF_ELEM,
    ST_OVF_ROWB,
    ST_OVF_ROWS,
    ST_OVF_TOTAL,
    ST_MISMATCH
  } status_t;

  typedef enum logic [1:0] {
    CLS_ADMIT,
    CLS_REMOVED,
    CLS_NEWER
  } cls_t;

  typedef struct packed {
    cls_t       cls;
    logic [8:0] block;
    logic [8:0] bytes;
  } geom_t;

  localparam geom_t GEOM_TABLE [TABLE_ROWS] = '{
    '{CLS_ADMIT, 9'd1, 9'd4},     '{CLS_ADMIT, 9'd1, 9'd2},     '{CLS_ADMIT, 9'd32, 9'd18},
    '{CLS_ADMIT, 9'd32, 9'd20},   '{CLS_REMOVED, 9'd0, 9'd0},   '{CLS_REMOVED, 9'd0, 9'd0},
    '{CLS_ADMIT, 9'd32, 9'd22},   '{CLS_ADMIT, 9'd32, 9'd24},   '{CLS_ADMIT, 9'd32, 9'd34},
    '{CLS_ADMIT, 9'd32, 9'd36},   '{CLS_ADMIT, 9'd256, 9'd84},  '{CLS_ADMIT, 9'd256, 9'd110},
    '{CLS_ADMIT, 9'd256, 9'd144}, '{CLS_ADMIT, 9'd256, 9'd176}, '{CLS_ADMIT, 9'd256, 9'd210},
    '{CLS_ADMIT, 9'd256, 9'd292}, '{CLS_ADMIT, 9'd256, 9'd66},  '{CLS_ADMIT, 9'd256, 9'd74},
    '{CLS_ADMIT, 9'd256, 9'd98},  '{CLS_ADMIT, 9'd256, 9'd50},  '{CLS_ADMIT, 9'd32, 9'd18},
    '{CLS_ADMIT, 9'd256, 9'd110}, '{CLS_ADMIT, 9'd256, 9'd82},  '{CLS_ADMIT, 9'd256, 9'd136},
    '{CLS_ADMIT, 9'd1, 9'd1},     '{CLS_ADMIT, 9'd1, 9'd2},     '{CLS_ADMIT, 9'd1, 9'd4},
    '{CLS_ADMIT, 9'd1, 9'd8},     '{CLS_ADMIT, 9'd1, 9'd8},     '{CLS_ADMIT, 9'd256, 9'd56},
    '{CLS_ADMIT, 9'd1, 9'd2},     '{CLS_REMOVED, 9'd0, 9'd0},   '{CLS_REMOVED, 9'd0, 9'd0},
    '{CLS_REMOVED, 9'd0, 9'd0},   '{CLS_ADMIT, 9'd256, 9'd54},  '{CLS_ADMIT, 9'd256, 9'd66},
    '{CLS_REMOVED, 9'd0, 9'd0},   '{CLS_REMOVED, 9'd0, 9'd0},   '{CLS_REMOVED, 9'd0, 9'd0},
    '{CLS_ADMIT, 9'd32, 9'd17},   '{CLS_NEWER, 9'd64, 9'd36},   '{CLS_NEWER, 9'd128, 9'd18},
    '{CLS_NEWER, 9'd64, 9'd18}
  };

  typedef struct packed {
    logic [7:0]  type_id;
    logic [3:0]  rank;
    logic [63:0] dim0;
    logic [63:0] dim1;
    logic [63:0] dim2;
    logic [63:0] dim3;
    logic        check_size;
    logic [63:0] declared_bytes;
  } desc_t;

  typedef struct packed {
    status_t     st;
    logic [63:0] q;
    logic [8:0]  bytes;
    logic [63:0] d0;
    logic [63:0] d1;
    logic [63:0] d2;
    logic [63:0] d3;
    logic        chk;
    logic [63:0] decl;
  } dec_t;

  typedef struct packed {
    status_t     st;
    logic        chk;
    logic [63:0] decl;
    logic [63:0] d0;
  } side_t;

  typedef struct packed {
    logic [NSTAGE-1:0] ld;
    logic              out_valid;
  } pipe_ctl_t;

  // Rows past the end of the table read as having no geometry.
  function automatic geom_t geom_lookup(input logic [7:0] id);
    geom_t g;
    g = '{CLS_ADMIT, 9'd0, 9'd0};
    if (32'(id) < TABLE_ROWS) begin
      g = GEOM_TABLE[id[TBL_IW-1:0]];
    end
    return g;
  endfunction

  // Block widths are powers of two, so the block divide is a shift.
  function automatic logic [3:0] blk_log2(input logic [8:0] blk);
    logic [3:0] s;
    s = 4'd0;
    for (int i = 0; i < 9; i++) begin
      if (blk[i]) begin
        s = 4'(i);
      end
    end
    return s;
  endfunction

endpackage

### rtl/core/qtsc_in_if.sv
// Descriptor channel of the tensor storage checker: valid, ready and payload.
// No dependencies.
interface qtsc_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  type_id;
  logic [3:0]  rank;
  logic [63:0] dim0;
  logic [63:0] dim1;
  logic [63:0] dim2;
  logic [63:0] dim3;
  logic        check_size;
  logic [63:0] declared_bytes;

  modport source (
    output valid, type_id, rank, dim0, dim1, dim2, dim3, check_size, declared_bytes,
    input  ready
  );
  modport sink (
    input  valid, type_id, rank, dim0, dim1, dim2, dim3, check_size, declared_bytes,
    output ready
  );
endinterface

### rtl/core/qtsc_out_if.sv
// Result channel of the tensor storage checker: valid, ready and payload.
// No dependencies.
interface qtsc_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  status;
  logic [63:0] row_size;
  logic [63:0] num_rows;
  logic [63:0] num_elems;
  logic [63:0] tensor_size;

  modport source (
    output valid, status, row_size, num_rows, num_elems, tensor_size,
    input  ready
  );
  modport sink (
    input  valid, status, row_size, num_rows, num_elems, tensor_size,
    output ready
  );
endinterface

### rtl/core/qtsc_ctl.sv
// Pipeline control: one valid bit per stage and per-stage load enables that
// let bubbles collapse under an output stall. Depends on qtsc_pkg.
module qtsc_ctl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 out_ready,
  output qtsc_pkg::pipe_ctl_t  ctl
);
  import qtsc_pkg::*;

  logic [NSTAGE-1:0] v_r;
  logic [NSTAGE-1:0] v_nxt;
  logic [NSTAGE-1:0] ld;

  always_comb begin
    ld[NSTAGE-1] = !v_r[NSTAGE-1] || out_ready;
    for (int k = NSTAGE - 2; k >= 0; k--) begin
      ld[k] = !v_r[k] || ld[k+1];
    end
    v_nxt[0] = ld[0] ? in_valid : v_r[0];
    for (int k = 1; k < NSTAGE; k++) begin
      v_nxt[k] = ld[k] ? v_r[k-1] : v_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign ctl.ld        = ld;
  assign ctl.out_valid = v_r[NSTAGE-1];

endmodule

### rtl/core/qtsc_decode.sv
// First stage: type table lookup, the ordered admission checks, the block
// shift and the effective outer dimensions, registered. Depends on qtsc_pkg.
module qtsc_decode (
  input  logic             clk,
  input  logic             ld,
  input  qtsc_pkg::desc_t  desc,
  output qtsc_pkg::dec_t   dec
);
  import qtsc_pkg::*;

  geom_t       g;
  logic [3:0]  sh;
  logic        rank_bad;
  logic        zero_dim;
  logic        blk_bad;
  status_t     st;
  dec_t        dec_nxt;
  dec_t        dec_r;

  always_comb begin
    g        = geom_lookup(desc.type_id);
    sh       = blk_log2(g.block);
    rank_bad = (desc.rank == 4'd0) || (32'(desc.rank) > MAX_RANK);
    zero_dim = (desc.dim0 == '0)
            || ((desc.rank > 4'd1) && (desc.dim1 == '0))
            || ((desc.rank > 4'd2) && (desc.dim2 == '0))
            || ((desc.rank > 4'd3) && (desc.dim3 == '0));
    blk_bad  = (desc.dim0 & (64'(g.block) - 64'd1)) != '0;

    if (32'(desc.type_id) >= TYPE_COUNT) begin
      st = ST_UNKNOWN;
    end else if (32'(desc.type_id) >= TABLE_ROWS) begin
      st = ST_RESERVED;
    end else if (g.cls == CLS_REMOVED) begin
      st = ST_REMOVED;
    end else if (g.cls == CLS_NEWER) begin
      st = ST_NEWER;
    end else if (g.block == '0 || g.bytes == '0) begin
      st = ST_NOGEOM;
    end else if (rank_bad) begin
      st = ST_RANK;
    end else if (zero_dim) begin
      st = ST_ZERODIM;
    end else if (blk_bad) begin
      st = ST_BLOCK;
    end else begin
      st = ST_OK;
    end

    dec_nxt.st    = st;
    dec_nxt.q     = desc.dim0 >> sh;
    dec_nxt.bytes = g.bytes;
    dec_nxt.d0    = desc.dim0;
    dec_nxt.d1    = (desc.rank > 4'd1) ? desc.dim1 : 64'd1;
    dec_nxt.d2    = (desc.rank > 4'd2) ? desc.dim2 : 64'd1;
    dec_nxt.d3    = (desc.rank > 4'd3) ? desc.dim3 : 64'd1;
    dec_nxt.chk   = desc.check_size;
    dec_nxt.decl  = desc.declared_bytes;
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      dec_r <= dec_nxt;
    end
  end

  assign dec = dec_r;

endmodule

### rtl/core/qtsc_mul64.sv
// Two-stage 64 by 64 multiplier with overflow flag: three 32 by 32 partial
// products, then their sum and the high-half check. Depends on qtsc_pkg.
module qtsc_mul64 (
  input  logic        clk,
  input  logic        ld_pp,
  input  logic        ld_sum,
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic [63:0] p,
  output logic        ovf
);
  import qtsc_pkg::*;

  logic [63:0] ll_r;
  logic [63:0] hl_r;
  logic [63:0] lh_r;
  logic        both_r;
  logic [64:0] mid;
  logic [63:0] p_nxt;
  logic        ovf_nxt;
  logic [63:0] p_r;
  logic        ovf_r;

  always_ff @(posedge clk) begin
    if (ld_pp) begin
      ll_r   <= 64'(a[31:0]) * 64'(b[31:0]);
      hl_r   <= 64'(a[63:32]) * 64'(b[31:0]);
      lh_r   <= 64'(a[31:0]) * 64'(b[63:32]);
      both_r <= (a[63:32] != '0) && (b[63:32] != '0);
    end
  end

  // When both high halves are nonzero the product overflows regardless of mid.
  always_comb begin
    mid     = 65'(hl_r) + 65'(lh_r) + 65'(ll_r[63:32]);
    ovf_nxt = both_r || (mid[64:32] != '0);
    p_nxt   = {mid[31:0], ll_r[31:0]};
  end

  always_ff @(posedge clk) begin
    if (ld_sum) begin
      p_r   <= p_nxt;
      ovf_r <= ovf_nxt;
    end
  end

  assign p   = p_r;
  assign ovf = ovf_r;

endmodule

### rtl/core/quant_tensor_storage_checker.sv
// Tensor storage checker: eight register stages, one descriptor per cycle while
// the result channel is not stalled. The pipeline depth is set by the row count
// product chain and the final products, each a two-stage 32-bit partial product unit.
// Reset clears the stage valid bits only; no clearing pass is needed.
// Depends on qtsc_pkg, qtsc_in_if, qtsc_out_if, qtsc_ctl, qtsc_decode, qtsc_mul64.
module quant_tensor_storage_checker (
  input  logic        clk,
  input  logic        rst_n,
  qtsc_in_if.sink     in_chan,
  qtsc_out_if.source  out_chan
);
  import qtsc_pkg::*;

  pipe_ctl_t    ctl;
  desc_t        desc;
  dec_t         dec;

  side_t        side_r [1:6];
  logic [72:0]  rbp1_r;
  logic [63:0]  d3_r [1:2];
  logic [63:0]  rb_r [2:6];
  logic         ovfrb_r [2:6];
  logic         ovf12_r [3:4];
  logic [63:0]  rows_r [5:6];
  logic         ovfrows_r [5:6];

  logic [63:0]  m12_p;
  logic         m12_ovf;
  logic [63:0]  rows_p;
  logic         rows_ovf;
  logic [63:0]  el_p;
  logic         el_ovf;
  logic [63:0]  tb_p;
  logic         tb_ovf;

  status_t      st_nxt;
  status_t      status_r;
  logic [63:0]  row_size_r;
  logic [63:0]  num_rows_r;
  logic [63:0]  num_elems_r;
  logic [63:0]  tensor_size_r;

  assign desc.type_id        = in_chan.type_id;
  assign desc.rank           = in_chan.rank;
  assign desc.dim0           = in_chan.dim0;
  assign desc.dim1           = in_chan.dim1;
  assign desc.dim2           = in_chan.dim2;
  assign desc.dim3           = in_chan.dim3;
  assign desc.check_size     = in_chan.check_size;
  assign desc.declared_bytes = in_chan.declared_bytes;

  qtsc_ctl u_ctl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .out_ready (out_chan.ready),
    .ctl       (ctl)
  );

  assign in_chan.ready = ctl.ld[0];

  qtsc_decode u_decode (
    .clk  (clk),
    .ld   (ctl.ld[0]),
    .desc (desc),
    .dec  (dec)
  );

  qtsc_mul64 u_mul_12 (
    .clk    (clk),
    .ld_pp  (ctl.ld[1]),
    .ld_sum (ctl.ld[2]),
    .a      (dec.d1),
    .b      (dec.d2),
    .p      (m12_p),
    .ovf    (m12_ovf)
  );

  qtsc_mul64 u_mul_rows (
    .clk    (clk),
    .ld_pp  (ctl.ld[3]),
    .ld_sum (ctl.ld[4]),
    .a      (m12_p),
    .b      (d3_r[2]),
    .p      (rows_p),
    .ovf    (rows_ovf)
  );

  qtsc_mul64 u_mul_elem (
    .clk    (clk),
    .ld_pp  (ctl.ld[5]),
    .ld_sum (ctl.ld[6]),
    .a      (side_r[4].d0),
    .b      (rows_p),
    .p      (el_p),
    .ovf    (el_ovf)
  );

  qtsc_mul64 u_mul_total (
    .clk    (clk),
    .ld_pp  (ctl.ld[5]),
    .ld_sum (ctl.ld[6]),
    .a      (rb_r[4]),
    .b      (rows_p),
    .p      (tb_p),
    .ovf    (tb_ovf)
  );

  always_ff @(posedge clk) begin
    if (ctl.ld[1]) begin
      side_r[1] <= '{dec.st, dec.chk, dec.decl, dec.d0};
      rbp1_r    <= 73'(dec.q) * 73'(dec.bytes);
      d3_r[1]   <= dec.d3;
    end
    if (ctl.ld[2]) begin
      side_r[2]  <= side_r[1];
      rb_r[2]    <= rbp1_r[63:0];
      ovfrb_r[2] <= rbp1_r[72:64] != '0;
      d3_r[2]    <= d3_r[1];
    end
    if (ctl.ld[3]) begin
      side_r[3]  <= side_r[2];
      rb_r[3]    <= rb_r[2];
      ovfrb_r[3] <= ovfrb_r[2];
      ovf12_r[3] <= m12_ovf;
    end
    if (ctl.ld[4]) begin
      side_r[4]  <= side_r[3];
      rb_r[4]    <= rb_r[3];
      ovfrb_r[4] <= ovfrb_r[3];
      ovf12_r[4] <= ovf12_r[3];
    end
    if (ctl.ld[5]) begin
      side_r[5]    <= side_r[4];
      rb_r[5]      <= rb_r[4];
      ovfrb_r[5]   <= ovfrb_r[4];
      rows_r[5]    <= rows_p;
      ovfrows_r[5] <= ovf12_r[4] || rows_ovf;
    end
    if (ctl.ld[6]) begin
      side_r[6]    <= side_r[5];
      rb_r[6]      <= rb_r[5];
      ovfrb_r[6]   <= ovfrb_r[5];
      rows_r[6]    <= rows_r[5];
      ovfrows_r[6] <= ovfrows_r[5];
    end
  end

  // The first failing check in the fixed order decides the status.
  always_comb begin
    if (side_r[6].st != ST_OK) begin
      st_nxt = side_r[6].st;
    end else if (ovfrb_r[6]) begin
      st_nxt = ST_OVF_ROWB;
    end else if (ovfrows_r[6]) begin
      st_nxt = ST_OVF_ROWS;
    end else if (el_ovf) begin
      st_nxt = ST_OVF_ELEM;
    end else if (tb_ovf) begin
      st_nxt = ST_OVF_TOTAL;
    end else if (side_r[6].chk && (tb_p != side_r[6].decl)) begin
      st_nxt = ST_MISMATCH;
    end else begin
      st_nxt = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ld[NSTAGE-1]) begin
      status_r      <= st_nxt;
      row_size_r    <= (st_nxt == ST_OK) ? rb_r[6]   : '0;
      num_rows_r    <= (st_nxt == ST_OK) ? rows_r[6] : '0;
      num_elems_r   <= (st_nxt == ST_OK) ? el_p      : '0;
      tensor_size_r <= (st_nxt == ST_OK) ? tb_p      : '0;
    end
  end

  assign out_chan.valid       = ctl.out_valid;
  assign out_chan.status      = status_r;
  assign out_chan.row_size    = row_size_r;
  assign out_chan.num_rows    = num_rows_r;
  assign out_chan.num_elems   = num_elems_r;
  assign out_chan.tensor_size = tensor_size_r;

endmodule

### rtl/core/qtsc_checker.sv
// Port-level checks for the tensor storage checker, attached by bind.
// Depends on qtsc_pkg, qtsc_in_if and qtsc_out_if.
module qtsc_checker (
  input  logic         clk,
  input  logic         rst_n,
  qtsc_in_if.sink      in_chan,
  qtsc_out_if.source   out_chan
);
  import qtsc_pkg::*;

  // A refused transaction reports no counts.
  a_refusal_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && (out_chan.status != ST_OK) |->
      (out_chan.row_size == '0) && (out_chan.num_rows == '0) &&
      (out_chan.num_elems == '0) && (out_chan.tensor_size == '0))
    else $error("refused result carries nonzero counts");

  // An accepted tensor always has at least one row, element and byte, and no fewer elements than rows.
  a_ok_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && (out_chan.status == ST_OK) |->
      (out_chan.row_size != '0) && (out_chan.num_rows != '0) &&
      (out_chan.num_elems != '0) && (out_chan.tensor_size != '0) &&
      (out_chan.num_elems >= out_chan.num_rows))
    else $error("accepted result has inconsistent counts");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && !out_chan.ready |=>
      out_chan.valid && $stable(out_chan.status) && $stable(out_chan.row_size) &&
      $stable(out_chan.num_rows) && $stable(out_chan.num_elems) &&
      $stable(out_chan.tensor_size))
    else $error("stalled result changed");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_chan.valid && in_chan.ready)
    else $error("pipeline not empty after reset");

endmodule

bind quant_tensor_storage_checker qtsc_checker u_qtsc_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_chan  (in_chan),
  .out_chan (out_chan)
);

### test/quant_tensor_storage_checker_test.sv
`timescale 1ns / 1ps
// Testbench for quant_tensor_storage_checker: directed and random tensor descriptors,
// with results compared field by field against a size predictor kept in this file.
// Depends on qtsc_pkg, qtsc_in_if, qtsc_out_if and the checker RTL.
module quant_tensor_storage_checker_test;
  import qtsc_pkg::*;

  localparam int unsigned NUM_TYPES   = 43;
  localparam int unsigned NUM_ROWS    = 43;
  localparam int unsigned GEOM_IW     = $clog2(NUM_ROWS);
  localparam int unsigned DIM_LIMIT   = 4;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned HOLD_CYCLES = 80;
  localparam int unsigned DRAIN_WAIT  = 20;

  typedef struct packed {
    cls_t        cls;
    logic [8:0]  block;
    logic [8:0]  bytes;
  } type_geom_t;

  typedef struct packed {
    status_t     status;
    logic [63:0] row_size;
    logic [63:0] num_rows;
    logic [63:0] num_elems;
    logic [63:0] tensor_size;
  } tensor_sizes_t;

  localparam type_geom_t TYPE_GEOM [NUM_ROWS] = '{
    '{CLS_ADMIT, 9'd1, 9'd4},     '{CLS_ADMIT, 9'd1, 9'd2},
    '{CLS_ADMIT, 9'd32, 9'd18},   '{CLS_ADMIT, 9'd32, 9'd20},
    '{CLS_REMOVED, 9'd0, 9'd0},   '{CLS_REMOVED, 9'd0, 9'd0},
    '{CLS_ADMIT, 9'd32, 9'd22},   '{CLS_ADMIT, 9'd32, 9'd24},
    '{CLS_ADMIT, 9'd32, 9'd34},   '{CLS_ADMIT, 9'd32, 9'd36},
    '{CLS_ADMIT, 9'd256, 9'd84},  '{CLS_ADMIT, 9'd256, 9'd110},
    '{CLS_ADMIT, 9'd256, 9'd144}, '{CLS_ADMIT, 9'd256, 9'd176},
    '{CLS_ADMIT, 9'd256, 9'd210}, '{CLS_ADMIT, 9'd256, 9'd292},
    '{CLS_ADMIT, 9'd256, 9'd66},  '{CLS_ADMIT, 9'd256, 9'd74},
    '{CLS_ADMIT, 9'd256, 9'd98},  '{CLS_ADMIT, 9'd256, 9'd50},
    '{CLS_ADMIT, 9'd32, 9'd18},   '{CLS_ADMIT, 9'd256, 9'd110},
    '{CLS_ADMIT, 9'd256, 9'd82},  '{CLS_ADMIT, 9'd256, 9'd136},
    '{CLS_ADMIT, 9'd1, 9'd1},     '{CLS_ADMIT, 9'd1, 9'd2},
    '{CLS_ADMIT, 9'd1, 9'd4},     '{CLS_ADMIT, 9'd1, 9'd8},
    '{CLS_ADMIT, 9'd1, 9'd8},     '{CLS_ADMIT, 9'd256, 9'd56},
    '{CLS_ADMIT, 9'd1, 9'd2},     '{CLS_REMOVED, 9'd0, 9'd0},
    '{CLS_REMOVED, 9'd0, 9'd0},   '{CLS_REMOVED, 9'd0, 9'd0},
    '{CLS_ADMIT, 9'd256, 9'd54},  '{CLS_ADMIT, 9'd256, 9'd66},
    '{CLS_REMOVED, 9'd0, 9'd0},   '{CLS_REMOVED, 9'd0, 9'd0},
    '{CLS_REMOVED, 9'd0, 9'd0},   '{CLS_ADMIT, 9'd32, 9'd17},
    '{CLS_NEWER, 9'd64, 9'd36},   '{CLS_NEWER, 9'd128, 9'd18},
    '{CLS_NEWER, 9'd64, 9'd18}
  };

  logic clk;
  logic rst_n;

  qtsc_in_if  in_chan ();
  qtsc_out_if out_chan ();

  quant_tensor_storage_checker dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  tensor_sizes_t pending_sizes [$];
  int          mismatches   = 0;
  int          stall_cycles = 0;
  int          burst_left   = 0;
  bit          steady_send  = 1'b0;
  int unsigned hold_seq     = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic bit mul_fits(input logic [63:0] a, input logic [63:0] b,
                                  output logic [63:0] p);
    logic [127:0] full;
    full = 128'(a) * 128'(b);
    p = full[63:0];
    return full[127:64] == 64'd0;
  endfunction

  function automatic tensor_sizes_t predict_sizes(input desc_t d);
    tensor_sizes_t r;
    type_geom_t    g;
    logic [63:0]   dims [4];
    logic [63:0]   rb;
    logic [63:0]   rows;
    logic [63:0]   elems;
    logic [63:0]   total;
    r = '0;
    r.status = ST_OK;
    dims[0] = d.dim0;
    dims[1] = d.dim1;
    dims[2] = d.dim2;
    dims[3] = d.dim3;
    if (32'(d.type_id) >= NUM_TYPES) begin
      r.status = ST_UNKNOWN;
      return r;
    end
    if (32'(d.type_id) >= NUM_ROWS) begin
      r.status = ST_RESERVED;
      return r;
    end
    g = TYPE_GEOM[d.type_id[GEOM_IW-1:0]];
    if (g.cls == CLS_REMOVED) begin
      r.status = ST_REMOVED;
      return r;
    end
    if (g.cls == CLS_NEWER) begin
      r.status = ST_NEWER;
      return r;
    end
    if (g.block == 9'd0 || g.bytes == 9'd0) begin
      r.status = ST_NOGEOM;
      return r;
    end
    if (d.rank == 4'd0 || 32'(d.rank) > DIM_LIMIT) begin
      r.status = ST_RANK;
      return r;
    end
    for (int k = 0; k < int'(d.rank); k++) begin
      if (dims[k] == 64'd0) begin
        r.status = ST_ZERODIM;
        return r;
      end
    end
    if (d.dim0 % 64'(g.block) != 64'd0) begin
      r.status = ST_BLOCK;
      return r;
    end
    if (!mul_fits(d.dim0 / 64'(g.block), 64'(g.bytes), rb)) begin
      r.status = ST_OVF_ROWB;
      return r;
    end
    rows = 64'd1;
    for (int k = 1; k < int'(d.rank); k++) begin
      if (!mul_fits(rows, dims[k], rows)) begin
        r.status = ST_OVF_ROWS;
        return r;
      end
    end
    if (!mul_fits(d.dim0, rows, elems)) begin
      r.status = ST_OVF_ELEM;
      return r;
    end
    if (!mul_fits(rb, rows, total)) begin
      r.status = ST_OVF_TOTAL;
      return r;
    end
    if (d.check_size && total != d.declared_bytes) begin
      r.status = ST_MISMATCH;
      return r;
    end
    r.row_size    = rb;
    r.num_rows    = rows;
    r.num_elems   = elems;
    r.tensor_size = total;
    return r;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] rand_dim();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return 64'($urandom_range(1, 64));
      6, 7: return 64'($urandom_range(1, 65535));
      8: return 64'd1 << $urandom_range(0, 63);
      default: return rand64();
    endcase
  endfunction

  function automatic desc_t make_desc(input logic [7:0] tid, input logic [3:0] rnk,
                                      input logic [63:0] d0, input logic [63:0] d1,
                                      input logic [63:0] d2, input logic [63:0] d3,
                                      input logic chk, input logic [63:0] decl);
    desc_t d;
    d.type_id        = tid;
    d.rank           = rnk;
    d.dim0           = d0;
    d.dim1           = d1;
    d.dim2           = d2;
    d.dim3           = d3;
    d.check_size     = chk;
    d.declared_bytes = decl;
    return d;
  endfunction

  // Admitted type, legal rank and block-aligned rows, with a few flaws mixed in.
  function automatic desc_t well_formed_desc();
    desc_t         d;
    tensor_sizes_t sz;
    logic [7:0]    t;
    do begin
      t = 8'($urandom_range(0, NUM_TYPES - 1));
    end while (TYPE_GEOM[t[GEOM_IW-1:0]].cls != CLS_ADMIT);
    d = make_desc(t, 4'($urandom_range(1, 4)),
                  64'(TYPE_GEOM[t[GEOM_IW-1:0]].block) * rand_dim(),
                  rand_dim(), rand_dim(), rand_dim(), 1'b0, 64'd0);
    if (d.rank < 4'd4) d.dim3 = rand64();
    if (d.rank < 4'd3) d.dim2 = rand64();
    if (d.rank < 4'd2) d.dim1 = rand64();
    if ($urandom_range(0, 19) == 0) begin
      d.dim0 = d.dim0 + 64'd1;
    end
    if ($urandom_range(0, 19) == 0) begin
      case ($urandom_range(0, int'(d.rank) - 1))
        0: d.dim0 = 64'd0;
        1: d.dim1 = 64'd0;
        2: d.dim2 = 64'd0;
        default: d.dim3 = 64'd0;
      endcase
    end
    sz = predict_sizes(d);
    d.check_size = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 3))
      0, 1: d.declared_bytes = sz.tensor_size;
      2: d.declared_bytes = sz.tensor_size ^ (64'd1 << $urandom_range(0, 63));
      default: d.declared_bytes = rand64();
    endcase
    return d;
  endfunction

  function automatic logic [63:0] noise_dim();
    case ($urandom_range(0, 7))
      0: return 64'd0;
      1, 2, 3: return rand_dim();
      default: return rand64();
    endcase
  endfunction

  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endfunction

  task automatic send_desc(input desc_t d);
    int gap;
    if (!steady_send && burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(1, 30);
      if (gap > 0) begin
        in_chan.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    if (burst_left > 0) burst_left--;
    in_chan.valid          <= 1'b1;
    in_chan.type_id        <= d.type_id;
    in_chan.rank           <= d.rank;
    in_chan.dim0           <= d.dim0;
    in_chan.dim1           <= d.dim1;
    in_chan.dim2           <= d.dim2;
    in_chan.dim3           <= d.dim3;
    in_chan.check_size     <= d.check_size;
    in_chan.declared_bytes <= d.declared_bytes;
    do @(posedge clk); while (!in_chan.ready);
    pending_sizes.push_back(predict_sizes(d));
  endtask

  task automatic test_type_classes();
    send_desc(make_desc(8'd255, 4'd1, 64'd1, 64'd1, 64'd1, 64'd1, 1'b0, 64'd0));
    send_desc(make_desc(8'd43, 4'd1, 64'd1, 64'd1, 64'd1, 64'd1, 1'b0, 64'd0));
    send_desc(make_desc(8'd4, 4'd1, 64'd32, 64'd1, 64'd1, 64'd1, 1'b0, 64'd0));
    send_desc(make_desc(8'd36, 4'd2, 64'd256, 64'd2, 64'd1, 64'd1, 1'b0, 64'd0));
    send_desc(make_desc(8'd40, 4'd1, 64'd64, 64'd1, 64'd1, 64'd1, 1'b0, 64'd0));
    send_desc(make_desc(8'd42, 4'd1, 64'd64, 64'd1, 64'd1, 64'd1, 1'b0, 64'd0));
    send_desc(make_desc(8'd0, 4'd1, 64'd1, 64'd0, 64'd0, 64'd0, 1'b0, 64'd0));
    send_desc(make_desc(8'd39, 4'd2, 64'd96, 64'd5, 64'd0, 64'd0, 1'b0, 64'd0));
  endtask

  task automatic test_rank_and_dims();
    send_desc(make_desc(8'd0, 4'd0, 64'd4, 64'd4, 64'd4, 64'd4, 1'b0, 64'd0));
    send_desc(make_desc(8'd0, 4'd5, 64'd4, 64'd4, 64'd4, 64'd4, 1'b0, 64'd0));
    send_desc(make_desc(8'd0, 4'd15, 64'd4, 64'd4, 64'd4, 64'd4, 1'b0, 64'd0));
    send_desc(make_desc(8'd1, 4'd4, 64'd4, 64'd4, 64'd4, 64'd0, 1'b0, 64'd0));
    send_desc(make_desc(8'd1, 4'd2, 64'd4, 64'd3, 64'd0, 64'd0, 1'b0, 64'd0));
    send_desc(make_desc(8'd2, 4'd1, 64'd0, 64'd1, 64'd1, 64'd1, 1'b0, 64'd0));
    send_desc(make_desc(8'd8, 4'd4, 64'd64, 64'd3, 64'd5, 64'd7, 1'b0, 64'd0));
  endtask

  task automatic test_block_and_overflow();
    send_desc(make_desc(8'd2, 4'd1, 64'd33, 64'd1, 64'd1, 64'd1, 1'b0, 64'd0));
    send_desc(make_desc(8'd27, 4'd1, 64'd1 << 62, 64'd1, 64'd1, 64'd1, 1'b0, 64'd0));
    send_desc(make_desc(8'd0, 4'd3, 64'd4, 64'd1 << 32, 64'd1 << 32, 64'd1, 1'b0, 64'd0));
    send_desc(make_desc(8'd10, 4'd2, 64'd1 << 63, 64'd2, 64'd1, 64'd1, 1'b0, 64'd0));
    send_desc(make_desc(8'd0, 4'd2, 64'd1 << 61, 64'd2, 64'd1, 64'd1, 1'b0, 64'd0));
    send_desc(make_desc(8'd24, 4'd4, '1, '1, '1, '1, 1'b1, '1));
    send_desc(make_desc(8'd24, 4'd1, '1, '1, '1, '1, 1'b1, '1));
  endtask

  task automatic test_declared_size();
    send_desc(make_desc(8'd12, 4'd2, 64'd256, 64'd3, 64'd0, 64'd0, 1'b1, 64'd432));
    send_desc(make_desc(8'd12, 4'd2, 64'd256, 64'd3, 64'd0, 64'd0, 1'b1, 64'd431));
    send_desc(make_desc(8'd12, 4'd2, 64'd256, 64'd3, 64'd0, 64'd0, 1'b0, 64'd7));
    send_desc(make_desc(8'd15, 4'd1, 64'd512, 64'd0, 64'd0, 64'd0, 1'b1, '1));
  endtask

  task automatic test_well_formed_traffic();
    repeat (330) send_desc(well_formed_desc());
  endtask

  task automatic test_noise();
    repeat (60) begin
      send_desc(make_desc(8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)),
                          noise_dim(), noise_dim(), noise_dim(), noise_dim(),
                          1'($urandom_range(0, 1)), rand64()));
    end
  endtask

  task automatic test_backpressure();
    steady_send = 1'b1;
    hold_seq <= hold_seq + 1;
    repeat (40) send_desc(well_formed_desc());
    steady_send = 1'b0;
  endtask

  // Result consumer: its stall pattern changes now and then, and it honors long holds.
  initial begin
    int          mode;
    int          mode_left;
    int          hold_left;
    int          phase;
    int unsigned seen_hold;
    mode      = 0;
    mode_left = 0;
    hold_left = 0;
    phase     = 0;
    seen_hold = 0;
    out_chan.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_seq != seen_hold) begin
        seen_hold = hold_seq;
        hold_left = HOLD_CYCLES;
      end
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 150);
      end
      mode_left--;
      phase = (phase + 1) % 5;
      if (hold_left > 0) begin
        hold_left--;
        out_chan.ready <= 1'b0;
      end else begin
        case (mode)
          0: out_chan.ready <= 1'b1;
          1: out_chan.ready <= ($urandom_range(0, 3) != 0);
          2: out_chan.ready <= (phase >= 2);
          default: out_chan.ready <= ($urandom_range(0, 9) < 3);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    tensor_sizes_t want;
    if (rst_n) begin
      if (out_chan.valid && out_chan.ready) begin
        if (pending_sizes.size() == 0) begin
          $error("Result transaction with no descriptor pending");
          mismatches++;
        end else begin
          want = pending_sizes.pop_front();
          check_field("status", 64'(want.status), 64'(out_chan.status));
          check_field("row_size", want.row_size, out_chan.row_size);
          check_field("num_rows", want.num_rows, out_chan.num_rows);
          check_field("num_elems", want.num_elems, out_chan.num_elems);
          check_field("tensor_size", want.tensor_size, out_chan.tensor_size);
        end
      end
      if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin
    rst_n                  = 1'b0;
    in_chan.valid          = 1'b0;
    in_chan.type_id        = '0;
    in_chan.rank           = '0;
    in_chan.dim0           = '0;
    in_chan.dim1           = '0;
    in_chan.dim2           = '0;
    in_chan.dim3           = '0;
    in_chan.check_size     = 1'b0;
    in_chan.declared_bytes = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_type_classes();
    test_rank_and_dims();
    test_block_and_overflow();
    test_declared_size();
    test_well_formed_traffic();
    test_backpressure();
    test_noise();

    in_chan.valid <= 1'b0;
    while (pending_sizes.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### quant_tensor_storage_checker.f
rtl/core/qtsc_pkg.sv
rtl/core/qtsc_in_if.sv
rtl/core/qtsc_out_if.sv
rtl/core/qtsc_ctl.sv
rtl/core/qtsc_decode.sv
rtl/core/qtsc_mul64.sv
rtl/core/quant_tensor_storage_checker.sv
rtl/core/qtsc_checker.sv
test/quant_tensor_storage_checker_test.sv
